>>> hdl/chvoc_pkg.sv
// Shared types, constants and arithmetic helpers of the channel vocoder.
package chvoc_pkg;

  localparam int MAX_BANDS   = 16;
  localparam int BAND_W      = 4;
  localparam int NBAND_W     = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 20;
  localparam int NCOEF       = 5;
  localparam int COEF_DEPTH  = MAX_BANDS * NCOEF;
  localparam int COEF_AW     = 7;
  localparam int PW          = 58;
  localparam int MA_W        = 33;
  localparam int MB_W        = 25;
  localparam int Y_W         = 24;
  localparam int ENV_W       = 18;
  localparam int X_W         = 21;
  localparam int SUM_W       = 34;
  localparam int STEP_W      = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;
  localparam logic [16:0] ATTACK_K = 17'd6554;
  localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};

  // coefficient slots
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_PHASE_INC = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MOD_GAIN  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_OUT_GAIN  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BAND_CNT  = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_LOAD     = 3'd1;
  localparam logic [2:0] OP_GAIN_MUL = 3'd2;
  localparam logic [2:0] OP_GAIN_ACC = 3'd3;
  localparam logic [2:0] OP_BAND     = 3'd4;
  localparam logic [2:0] OP_FIN_MUL  = 3'd5;
  localparam logic [2:0] OP_FIN_OUT  = 3'd6;
  localparam logic [2:0] OP_CWR      = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic              zero_out;
    logic [STEP_W-1:0] step;
    logic [BAND_W-1:0] band;
  } dp_cmd_t;

  typedef struct packed {
    logic [NBAND_W-1:0] nbands;
  } dp_sts_t;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int k);
    rnd = (v + (PW'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > PW'(64'sh7FFFFFFF)) sat32 = 32'sh7FFFFFFF;
    else if (v < -PW'(64'sh80000000)) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [Y_W-1:0] sat24(input logic signed [PW-1:0] v);
    if (v > PW'(64'sh7FFFFF)) sat24 = 24'sh7FFFFF;
    else if (v < -PW'(64'sh800000)) sat24 = 24'sh800000;
    else sat24 = v[Y_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat16(input logic signed [PW-1:0] v);
    if (v > PW'(64'sh7FFF)) sat16 = 16'sh7FFF;
    else if (v < -PW'(64'sh8000)) sat16 = 16'sh8000;
    else sat16 = v[SAMPLE_BITS-1:0];
  endfunction

  // coefficient read one step ahead of its use
  function automatic logic [2:0] rd_slot(input logic [STEP_W-1:0] s);
    case (s)
      4'd0, 4'd5: rd_slot = SLOT_B0;
      4'd1, 4'd6: rd_slot = SLOT_B1;
      4'd2, 4'd7: rd_slot = SLOT_A1;
      4'd3, 4'd8: rd_slot = SLOT_B2;
      4'd4, 4'd9: rd_slot = SLOT_A2;
      default:    rd_slot = SLOT_B0;
    endcase
  endfunction

endpackage

>>> hdl/chvoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chvoc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/chvoc_ctrl.sv
// Sequencer of the vocoder: item handshake, band and step counting, output valid.
module chvoc_ctrl
  import chvoc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_mode,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAIN = 3'd1;
  localparam logic [2:0] S_GACC = 3'd2;
  localparam logic [2:0] S_BAND = 3'd3;
  localparam logic [2:0] S_FMUL = 3'd4;
  localparam logic [2:0] S_FOUT = 3'd5;
  localparam logic [2:0] S_ZOUT = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    band_nxt      = band_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NONE;
    cmd.zero_out  = 1'b0;
    cmd.step      = step_r;
    cmd.band      = band_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_mode) begin
            cmd.op    = OP_CWR;
            state_nxt = S_ZOUT;
          end else begin
            cmd.op    = OP_LOAD;
            state_nxt = S_GAIN;
          end
        end
      end
      S_GAIN: begin
        cmd.op    = OP_GAIN_MUL;
        state_nxt = S_GACC;
      end
      S_GACC: begin
        cmd.op    = OP_GAIN_ACC;
        step_nxt  = '0;
        band_nxt  = '0;
        state_nxt = (sts.nbands == '0) ? S_FMUL : S_BAND;
      end
      S_BAND: begin
        cmd.op = OP_BAND;
        if (step_r == LAST_STEP) begin
          step_nxt = '0;
          if ({1'b0, band_r} == sts.nbands - NBAND_W'(1)) begin
            state_nxt = S_FMUL;
          end else begin
            band_nxt = band_r + BAND_W'(1);
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FMUL: begin
        cmd.op    = OP_FIN_MUL;
        state_nxt = S_FOUT;
      end
      S_FOUT, S_ZOUT: begin
        if (slot_free) begin
          cmd.op        = OP_FIN_OUT;
          cmd.zero_out  = (state_r == S_ZOUT);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      band_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      band_r      <= band_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/chvoc_dp.sv
// Vocoder datapath: registers, coefficient RAM, shared multiplier, filter and envelope state.
module chvoc_dp
  import chvoc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_AW-1:0]             cfg_addr,
  input  logic [CFG_DW-1:0]             cfg_wdata,
  input  logic [IN_TDATA_W-1:0]         in_tdata,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  output logic [SAMPLE_BITS-1:0]        out_tdata
);

  logic [31:0]           phase_inc_r;
  logic [15:0]           mod_gain_r, out_gain_r, release_r;
  logic [NBAND_W-1:0]    band_cnt_r;
  logic [31:0]           phase_r;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] car_r;
  logic signed [X_W-1:0]         x_r;
  logic signed [PW-1:0]          prod_r, t_r;
  logic signed [Y_W-1:0]         yc_r, ym_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0]        out_r;

  logic signed [31:0]    cs1_r [MAX_BANDS];
  logic signed [31:0]    cs2_r [MAX_BANDS];
  logic signed [31:0]    ms1_r [MAX_BANDS];
  logic signed [31:0]    ms2_r [MAX_BANDS];
  logic [ENV_W-1:0]      env_r [MAX_BANDS];

  logic                  coef_we;
  logic [COEF_AW-1:0]    coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0]  coef_q;
  logic [3:0]            in_band;
  logic [2:0]            in_slot;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MB_W-1:0] coef_ext;
  logic signed [PW-1:0]   mul_p;

  logic signed [31:0]    s1_sel, s2_sel;
  logic signed [PW-1:0]  s1_ext, s2_ext;
  logic signed [Y_W-1:0] y_new;
  logic signed [31:0]    n1_new, n2_new;
  logic [Y_W-1:0]        ym_abs;
  logic [ENV_W-1:0]      r_w, env_old, env_new;
  logic [16:0]           k_w;
  logic signed [ENV_W:0] diff_w;
  logic signed [PW-1:0]  env_add, band_add, fin_rnd, x_rnd;
  logic signed [31:0]    sum_sat;

  assign in_band    = in_tdata[19:16];
  assign in_slot    = in_tdata[22:20];
  assign coef_we    = (cmd.op == OP_CWR) && (in_slot <= SLOT_A2);
  assign coef_waddr = COEF_AW'({in_band, 2'b00}) + COEF_AW'(in_band) + COEF_AW'(in_slot);
  assign coef_raddr = COEF_AW'({cmd.band, 2'b00}) + COEF_AW'(cmd.band)
                      + COEF_AW'(rd_slot(cmd.step));

  chvoc_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_tdata[42:23]),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  assign sts.nbands = (band_cnt_r > NBAND_W'(MAX_BANDS)) ? NBAND_W'(MAX_BANDS) : band_cnt_r;
  assign out_tdata  = out_r;

  // operand select for the shared multiplier
  assign coef_ext = MB_W'(signed'(coef_q));
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_GAIN_MUL: begin
        mul_a = MA_W'(sample_r);
        mul_b = MB_W'(mod_gain_r);
      end
      OP_BAND: begin
        case (cmd.step)
          4'd1, 4'd2, 4'd4: begin
            mul_a = MA_W'(car_r);
            mul_b = coef_ext;
          end
          4'd3, 4'd5: begin
            mul_a = MA_W'(yc_r);
            mul_b = coef_ext;
          end
          4'd6, 4'd7, 4'd9: begin
            mul_a = MA_W'(x_r);
            mul_b = coef_ext;
          end
          4'd8, 4'd10: begin
            mul_a = MA_W'(ym_r);
            mul_b = coef_ext;
          end
          4'd11: begin
            mul_a = MA_W'(diff_w);
            mul_b = MB_W'(k_w);
          end
          4'd13: begin
            mul_a = MA_W'(yc_r);
            mul_b = MB_W'(env_r[cmd.band]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      OP_FIN_MUL: begin
        mul_a = MA_W'(sum_sat);
        mul_b = MB_W'(out_gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // biquad accumulation on the registered product
  always_comb begin
    if (cmd.step < 4'd7) begin
      s1_sel = cs1_r[cmd.band];
      s2_sel = cs2_r[cmd.band];
    end else begin
      s1_sel = ms1_r[cmd.band];
      s2_sel = ms2_r[cmd.band];
    end
  end
  assign s1_ext = PW'(s1_sel) <<< 11;
  assign s2_ext = PW'(s2_sel) <<< 11;
  assign y_new  = sat24(rnd(prod_r + s1_ext, 16));
  assign n1_new = sat32(rnd(t_r - prod_r + s2_ext, 11));
  assign n2_new = sat32(rnd(t_r - prod_r, 11));

  // envelope follower
  assign ym_abs  = ym_r[Y_W-1] ? Y_W'(-ym_r) : Y_W'(ym_r);
  assign r_w     = (ym_abs > Y_W'(ENV_MAX)) ? ENV_MAX : ym_abs[ENV_W-1:0];
  assign env_old = env_r[cmd.band];
  assign k_w     = (r_w > env_old) ? ATTACK_K : {1'b0, release_r};
  assign diff_w  = signed'({1'b0, env_old}) - signed'({1'b0, r_w});
  assign env_add = rnd(prod_r, 16);
  assign env_new = r_w + env_add[ENV_W-1:0];

  assign band_add = rnd(prod_r, 15);
  assign sum_sat  = sat32(PW'(sum_r));
  assign fin_rnd  = rnd(prod_r, 12);
  assign x_rnd    = rnd(prod_r, 12);

  always_ff @(posedge clk) begin
    // product holds while the finished sample waits for the output register
    if (cmd.op != OP_NONE) begin
      prod_r <= mul_p;
    end
    case (cmd.op)
      OP_LOAD: begin
        sample_r <= signed'(in_tdata[SAMPLE_BITS-1:0]);
        car_r    <= signed'({~phase_r[31], phase_r[30:16]});
        sum_r    <= '0;
      end
      OP_GAIN_ACC: begin
        x_r <= x_rnd[X_W-1:0];
      end
      OP_BAND: begin
        case (cmd.step)
          4'd2:                  yc_r <= y_new;
          4'd7:                  ym_r <= y_new;
          4'd3, 4'd5, 4'd8, 4'd10: t_r <= prod_r;
          4'd14:                 sum_r <= sum_r + band_add[SUM_W-1:0];
          default: ;
        endcase
      end
      OP_FIN_OUT: begin
        out_r <= cmd.zero_out ? '0 : sat16(fin_rnd);
      end
      default: ;
    endcase
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= 32'd19685267;
      mod_gain_r  <= 16'd4096;
      out_gain_r  <= 16'd4096;
      release_r   <= 16'd65508;
      band_cnt_r  <= 5'd8;
      phase_r     <= '0;
      for (int i = 0; i < MAX_BANDS; i++) begin
        cs1_r[i] <= '0;
        cs2_r[i] <= '0;
        ms1_r[i] <= '0;
        ms2_r[i] <= '0;
        env_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_INC: phase_inc_r <= cfg_wdata;
          REG_MOD_GAIN:  mod_gain_r  <= cfg_wdata[15:0];
          REG_OUT_GAIN:  out_gain_r  <= cfg_wdata[15:0];
          REG_RELEASE:   release_r   <= cfg_wdata[15:0];
          REG_BAND_CNT:  band_cnt_r  <= cfg_wdata[NBAND_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        phase_r <= phase_r + phase_inc_r;
      end
      if (cmd.op == OP_BAND) begin
        case (cmd.step)
          4'd4:  cs1_r[cmd.band] <= n1_new;
          4'd6:  cs2_r[cmd.band] <= n2_new;
          4'd9:  ms1_r[cmd.band] <= n1_new;
          4'd11: ms2_r[cmd.band] <= n2_new;
          4'd12: env_r[cmd.band] <= env_new;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/channel_vocoder.sv
// Top level of the channel vocoder: sequencer plus datapath.
// One item is handled at a time. An audio word is worked through by the single shared
// multiplier that runs every band's carrier biquad, modulator biquad, envelope and band
// product in turn. The result sits in an output register, so the block takes the next
// word while the previous result waits; a finished result is held until that register frees.
module channel_vocoder
  import chvoc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] sample, [19:16] coef_band, [22:20] coef_slot, [42:23] coef_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] out_sample
  output logic [SAMPLE_BITS-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  chvoc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  chvoc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

>>> tb/sv/channel_vocoder_tb.sv
// Testbench of the channel vocoder: random and directed words checked against a bit-true predictor.
module channel_vocoder_tb;
  import chvoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE = 300;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [SAMPLE_BITS-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  channel_vocoder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  longint coefs [MAX_BANDS][NCOEF];
  longint car_mem [MAX_BANDS][2];
  longint mod_mem [MAX_BANDS][2];
  longint envs [MAX_BANDS];
  logic [31:0] phase;
  logic [31:0] phase_inc;
  logic [15:0] mod_gain;
  logic [15:0] out_gain;
  logic [15:0] release_k;
  logic [4:0] nbands;

  logic [SAMPLE_BITS-1:0] expected_samples [$];
  int errors;
  bit no_idle;
  bit hold_req;
  longint cycles;

  function automatic longint rshift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint biquad_step(int b, inout longint m0, inout longint m1, input longint x);
    longint y;
    longint n1;
    longint n2;
    y = clamp(rshift(coefs[b][SLOT_B0] * x + m0 * 2048, 16), Y_W);
    n1 = clamp(rshift(coefs[b][SLOT_B1] * x - coefs[b][SLOT_A1] * y + m1 * 2048, 11), 32);
    n2 = clamp(rshift(coefs[b][SLOT_B2] * x - coefs[b][SLOT_A2] * y, 11), 32);
    m0 = n1;
    m1 = n2;
    return y;
  endfunction

  function automatic logic [15:0] vocode(bit mode, logic [15:0] smp, logic [3:0] band,
                                         logic [2:0] slot, logic [19:0] val);
    longint x, car, sum, yc, ym, r, k, o;
    int active;
    if (mode) begin
      if (slot <= SLOT_A2) coefs[band][slot] = longint'($signed(val));
      return '0;
    end
    x = rshift(longint'($signed(smp)) * longint'(mod_gain), 12);
    car = longint'(phase[31:16]) - 32768;
    phase = phase + phase_inc;
    active = nbands > MAX_BANDS ? MAX_BANDS : nbands;
    sum = 0;
    for (int b = 0; b < active; b++) begin
      yc = biquad_step(b, car_mem[b][0], car_mem[b][1], car);
      ym = biquad_step(b, mod_mem[b][0], mod_mem[b][1], x);
      r = ym < 0 ? -ym : ym;
      if (r > longint'(ENV_MAX)) r = longint'(ENV_MAX);
      k = r > envs[b] ? longint'(ATTACK_K) : longint'(release_k);
      envs[b] = r + rshift((envs[b] - r) * k, 16);
      sum += rshift(yc * envs[b], 15);
    end
    sum = clamp(sum, 32);
    o = clamp(rshift(sum * longint'(out_gain), 12), 16);
    return o[15:0];
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 0;
      end else stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_samples.size() == 0) begin
        $error("out_sample: unexpected word, actual %0d", $signed(out_tdata));
        errors++;
      end else begin
        logic [15:0] want;
        want = expected_samples.pop_front();
        if (want !== out_tdata) begin
          $error("out_sample: expected %0d, actual %0d", $signed(want), $signed(out_tdata));
          errors++;
        end
      end
    end
  end

  task automatic send_word(bit mode, logic [15:0] smp, logic [3:0] band, logic [2:0] slot,
                           logic [19:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {5'd0, val, slot, band, smp};
    do @(posedge clk); while (!in_tready);
    expected_samples = {expected_samples, vocode(mode, smp, band, slot, val)};
  endtask

  task automatic send_sample(logic [15:0] smp);
    send_word(1'b0, smp, 4'($urandom), 3'($urandom), 20'($urandom));
  endtask

  task automatic send_coef(logic [3:0] band, logic [2:0] slot, logic [19:0] val);
    send_word(1'b1, 16'($urandom), band, slot, val);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] pinc, logic [15:0] mg, logic [15:0] og,
                            logic [15:0] rel, logic [4:0] nb);
    logic [31:0] vals [5];
    vals = '{pinc, 32'(mg), 32'(og), 32'(rel), 32'(nb)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_addr <= CFG_AW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    phase_inc = pinc;
    mod_gain = mg;
    out_gain = og;
    release_k = rel;
    nbands = nb;
  endtask

  task automatic load_band(int b);
    int a1, a2, b0;
    a2 = $urandom_range(30000, 62000);
    a1 = $urandom_range(0, 2 * (65536 + a2 - 2000)) - (65536 + a2 - 2000);
    b0 = $urandom_range(0, 16000) - 8000;
    send_coef(4'(b), SLOT_B0, 20'(b0));
    send_coef(4'(b), SLOT_B1, 20'd0);
    send_coef(4'(b), SLOT_B2, 20'(-b0));
    send_coef(4'(b), SLOT_A1, 20'(a1));
    send_coef(4'(b), SLOT_A2, 20'(a2));
  endtask

  function automatic logic [15:0] rand_sample;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_load_coefficients;
    for (int b = 0; b < MAX_BANDS; b++) load_band(b);
  endtask

  task automatic test_directed;
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h7FFF);
    send_coef(4'd3, 3'd5, 20'h7FFFF);
    send_coef(4'd15, 3'd6, 20'h80000);
    send_coef(4'd0, 3'd7, 20'h12345);
    send_coef(4'd15, SLOT_B0, 20'h7FFFF);
    send_coef(4'd15, SLOT_A1, 20'h80000);
    send_coef(4'd15, SLOT_A2, 20'h7FFFF);
    drain();
    write_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0, 5'd16);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF);
    send_coef(4'd15, SLOT_B0, 20'h80000);
    send_sample(16'h7FFF);
    load_band(15);
    drain();
  endtask

  task automatic test_config_sweep;
    logic [31:0] pincs [8] = '{32'd0, 32'hFFFF_FFFF, 32'd19685267, 32'h4000_0000,
                               32'd1, 32'h8000_0000, 32'h0123_4567, 32'd60000000};
    logic [4:0] counts [8] = '{5'd0, 5'd3, 5'd4, 5'd16, 5'd17, 5'd31, 5'd1, 5'd8};
    logic [15:0] gains [8] = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd8192, 16'd2048,
                               16'h8000, 16'd12000};
    for (int s = 0; s < 8; s++) begin
      drain();
      write_regs(pincs[s], gains[s], gains[7 - s], s[0] ? 16'hFFFF : 16'($urandom),
                 counts[s]);
      for (int i = 0; i < 110; i++) send_sample(rand_sample());
    end
    drain();
    write_regs(32'd19685267, 16'd4096, 16'd4096, 16'd65508, 5'd8);
  endtask

  task automatic test_random;
    for (int i = 0; i < 230; i++) begin
      case ($urandom_range(0, 39))
        0: load_band($urandom_range(0, 15));
        1: send_coef(4'($urandom), 3'($urandom_range(5, 7)), 20'($urandom));
        2: send_coef(4'($urandom), 3'($urandom_range(0, 4)), 20'($urandom));
        default: send_sample(rand_sample());
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_req = 1;
    for (int i = 0; i < 40; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_no_idle;
    no_idle = 1;
    for (int i = 0; i < 120; i++) send_sample(rand_sample());
    drain();
    no_idle = 0;
  endtask

  initial begin
    errors = 0;
    no_idle = 0;
    hold_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    foreach (coefs[b, s]) coefs[b][s] = 0;
    foreach (car_mem[b, j]) begin
      car_mem[b][j] = 0;
      mod_mem[b][j] = 0;
    end
    foreach (envs[b]) envs[b] = 0;
    phase = 0;
    phase_inc = 32'd19685267;
    mod_gain = 16'd4096;
    out_gain = 16'd4096;
    release_k = 16'd65508;
    nbands = 5'd8;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_load_coefficients();
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    test_no_idle();
    test_random();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/chvoc_pkg.sv
hdl/chvoc_ram.sv
hdl/chvoc_ctrl.sv
hdl/chvoc_dp.sv
hdl/channel_vocoder.sv
tb/sv/channel_vocoder_tb.sv
